@@ rtl/rc4_pkg.sv @@
// Shared constants and codes for the RC4 keystream engine.
// No dependencies; compiled first.
`timescale 1ns / 1ps
`default_nettype none

package rc4_pkg;

	localparam int PERM_DEPTH = 256;
	localparam int KEY_DEPTH  = 256;
	localparam int KEY_IDX_W  = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
	localparam int KEY_CNT_W  = $clog2(KEY_DEPTH + 1);

	typedef enum logic [1:0] {
		OP_LOAD     = 2'd0,
		OP_SCHEDULE = 2'd1,
		OP_CRYPT    = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_EMPTY_KEY = 2'd2
	} status_t;

endpackage

`default_nettype wire

@@ rtl/rc4_if.sv @@
// Valid/ready channel interfaces for request and response items.
// No dependencies beyond the language; compiled after rc4_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface rc4_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] operation;
	logic [7:0] data_byte;
	logic       last_of_message;

	modport source (output valid, output operation, output data_byte,
		output last_of_message, input ready);
	modport sink (input valid, input operation, input data_byte,
		input last_of_message, output ready);
endinterface

interface rc4_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic [1:0] status;

	modport source (output valid, output out_byte, output status, input ready);
	modport sink (input valid, input out_byte, input status, output ready);
endinterface

`default_nettype wire

@@ rtl/rc4_keystream_cipher.sv @@
// RC4 engine top level: permutation memory, key store and sequencer.
// Depends on rc4_pkg and the channel interfaces in rc4_if.sv.
`timescale 1ns / 1ps
`default_nettype none

// Channel | Dir | Payload                                  | Handshake
// req     | in  | operation, data_byte, last_of_message    | valid/ready
// rsp     | out | out_byte, status                         | valid/ready
//
// Crypt and key schedule steps go through the one permutation memory
// (one read and one write per cycle, registered read); key load and the
// unused code do not use it.
// Reset needs no clearing pass: one valid bit per permutation entry makes an
// unwritten entry read as its own index; a schedule clears all bits at once.
// A finished result waits in the output register; the next item is taken
// while it waits and only its own completion stalls on a full output.

module rc4_keystream_cipher (
	input  wire logic  clk,
	input  wire logic  arst_n,
	rc4_req_if.sink    req,
	rc4_rsp_if.source  rsp
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_CR_J,     // a = S[i], issue read of S[j]
		S_CR_SWAP,  // b = S[j], write S[i]=b, issue read of S[a+b]
		S_CR_OUT,   // write S[j]=a, form keystream byte
		S_KS_RD,    // issue read of S[n] and key byte
		S_KS_MIX,   // j += S[n] + key, issue read of S[j]
		S_KS_WRN,   // write S[n] = S[j]
		S_KS_WRJ,   // write S[j] = old S[n], advance n
		S_PUSH      // move result into output register
	} state_t;

	state_t state_q;

	// permutation memory with per-entry valid bits (invalid reads as index)
	logic [7:0]                      perm_mem [rc4_pkg::PERM_DEPTH];
	logic [rc4_pkg::PERM_DEPTH-1:0]  perm_vld_q;
	logic [7:0]                      rd_addr, wr_addr, wr_data;
	logic                            wr_en;
	logic [7:0]                      mem_rd_q, rd_addr_q, rd_data;
	logic                            rd_hit_q;

	// key store, undefined until written
	logic [7:0]                      key_mem [rc4_pkg::KEY_DEPTH];
	logic [7:0]                      key_rd_q;
	logic                            key_wr_en;
	logic [rc4_pkg::KEY_CNT_W-1:0]   key_count_q, sched_len_q;
	logic [rc4_pkg::KEY_IDX_W-1:0]   kp_q;

	// stream indices and working registers
	logic [7:0]  i_q, j_q, n_q, a_q, b_q, t_q, data_q;
	logic        last_q;
	logic [7:0]  j_mix, ks;
	logic        accept;
	logic        key_room;

	logic [7:0]       res_byte_q, out_byte_q;
	rc4_pkg::status_t res_status_q, out_status_q;
	logic             out_valid_q;

	assign accept     = req.valid && req.ready;
	assign req.ready  = (state_q == S_IDLE);
	assign rsp.valid  = out_valid_q;
	assign rsp.out_byte = out_byte_q;
	assign rsp.status = out_status_q;

	assign rd_data  = rd_hit_q ? mem_rd_q : rd_addr_q;
	assign j_mix    = j_q + rd_data + key_rd_q;
	assign key_room = (key_count_q < rc4_pkg::KEY_CNT_W'(rc4_pkg::KEY_DEPTH));
	assign key_wr_en = accept && (req.operation == rc4_pkg::OP_LOAD) && key_room;

	// keystream byte: S[a+b] after the swap; j slot wins over i slot
	assign ks = (t_q == j_q) ? a_q : ((t_q == i_q) ? b_q : rd_data);

	always_comb begin
		rd_addr = n_q;
		wr_en   = 1'b0;
		wr_addr = n_q;
		wr_data = rd_data;
		unique case (state_q)
			S_IDLE: begin
				rd_addr = i_q + 8'd1;
			end
			S_CR_J: begin
				rd_addr = j_q + rd_data;
			end
			S_CR_SWAP: begin
				rd_addr = a_q + rd_data;
				wr_en   = 1'b1;
				wr_addr = i_q;
				wr_data = rd_data;
			end
			S_CR_OUT: begin
				wr_en   = 1'b1;
				wr_addr = j_q;
				wr_data = a_q;
			end
			S_KS_MIX: begin
				rd_addr = j_mix;
			end
			S_KS_WRN: begin
				wr_en   = 1'b1;
				wr_addr = n_q;
				wr_data = rd_data;
			end
			S_KS_WRJ: begin
				wr_en   = 1'b1;
				wr_addr = j_q;
				wr_data = a_q;
			end
			default: begin
				rd_addr = n_q;
			end
		endcase
	end

	// memories: read-old on a same-cycle write to the same entry
	always_ff @(posedge clk) begin
		if (wr_en) begin
			perm_mem[wr_addr] <= wr_data;
		end
		mem_rd_q  <= perm_mem[rd_addr];
		rd_hit_q  <= perm_vld_q[rd_addr];
		rd_addr_q <= rd_addr;
	end

	always_ff @(posedge clk) begin
		if (key_wr_en) begin
			key_mem[key_count_q[rc4_pkg::KEY_IDX_W-1:0]] <= req.data_byte;
		end
		key_rd_q <= key_mem[kp_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			out_valid_q  <= 1'b0;
			out_byte_q   <= '0;
			out_status_q <= rc4_pkg::ST_OK;
			res_byte_q   <= '0;
			res_status_q <= rc4_pkg::ST_OK;
			perm_vld_q   <= '0;
			key_count_q  <= '0;
			sched_len_q  <= '0;
			kp_q         <= '0;
			i_q          <= '0;
			j_q          <= '0;
			n_q          <= '0;
			a_q          <= '0;
			b_q          <= '0;
			t_q          <= '0;
			data_q       <= '0;
			last_q       <= 1'b0;
		end else begin
			// a taken result frees the output; in S_PUSH the new one replaces it
			if (rsp.valid && rsp.ready && (state_q != S_PUSH)) begin
				out_valid_q <= 1'b0;
			end
			if (wr_en) begin
				perm_vld_q[wr_addr] <= 1'b1;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						data_q     <= req.data_byte;
						last_q     <= req.last_of_message;
						res_byte_q <= '0;
						unique case (req.operation)
							rc4_pkg::OP_LOAD: begin
								if (key_room) begin
									key_count_q  <= key_count_q + 1'b1;
									res_status_q <= rc4_pkg::ST_OK;
								end else begin
									res_status_q <= rc4_pkg::ST_FULL;
								end
								state_q <= S_PUSH;
							end
							rc4_pkg::OP_SCHEDULE: begin
								// back to identity, then the mixing pass
								perm_vld_q <= '0;
								j_q        <= '0;
								n_q        <= '0;
								kp_q       <= '0;
								if (key_count_q == '0) begin
									sched_len_q  <= rc4_pkg::KEY_CNT_W'(1);
									res_status_q <= rc4_pkg::ST_EMPTY_KEY;
								end else begin
									sched_len_q  <= key_count_q;
									res_status_q <= rc4_pkg::ST_OK;
								end
								state_q <= S_KS_RD;
							end
							rc4_pkg::OP_CRYPT: begin
								res_status_q <= rc4_pkg::ST_OK;
								i_q          <= i_q + 8'd1;
								state_q      <= S_CR_J;
							end
							default: begin
								res_status_q <= rc4_pkg::ST_OK;
								state_q      <= S_PUSH;
							end
						endcase
					end
				end
				S_CR_J: begin
					a_q     <= rd_data;
					j_q     <= j_q + rd_data;
					state_q <= S_CR_SWAP;
				end
				S_CR_SWAP: begin
					b_q     <= rd_data;
					t_q     <= a_q + rd_data;
					state_q <= S_CR_OUT;
				end
				S_CR_OUT: begin
					res_byte_q <= data_q ^ ks;
					if (last_q) begin
						i_q <= '0;
						j_q <= '0;
					end
					state_q <= S_PUSH;
				end
				S_KS_RD: begin
					state_q <= S_KS_MIX;
				end
				S_KS_MIX: begin
					a_q     <= rd_data;
					j_q     <= j_mix;
					state_q <= S_KS_WRN;
				end
				S_KS_WRN: begin
					state_q <= S_KS_WRJ;
				end
				S_KS_WRJ: begin
					n_q <= n_q + 8'd1;
					// key index runs n mod key length
					if (rc4_pkg::KEY_CNT_W'(kp_q) + rc4_pkg::KEY_CNT_W'(1) == sched_len_q)
					begin
						kp_q <= '0;
					end else begin
						kp_q <= kp_q + rc4_pkg::KEY_IDX_W'(1);
					end
					if (n_q == 8'hFF) begin
						key_count_q <= '0;
						i_q         <= '0;
						j_q         <= '0;
						state_q     <= S_PUSH;
					end else begin
						state_q <= S_KS_RD;
					end
				end
				S_PUSH: begin
					if (!out_valid_q || rsp.ready) begin
						out_valid_q  <= 1'b1;
						out_byte_q   <= res_byte_q;
						out_status_q <= res_status_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

@@ rtl/rc4_checker.sv @@
// Port-level checks for rc4_keystream_cipher, attached by bind.
// Depends on rc4_pkg; sees only the top-level channel signals.
`timescale 1ns / 1ps
`default_nettype none

module rc4_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       req_valid,
	input wire logic       req_ready,
	input wire logic       rsp_valid,
	input wire logic       rsp_ready,
	input wire logic [7:0] rsp_out_byte,
	input wire logic [1:0] rsp_status
);

	// a waiting result is not withdrawn
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("rsp valid dropped before taken");

	// ready drops once an item is accepted: each item keeps the engine busy
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("ready stayed high after accept");

	// no result can appear in the cycle right after an accept
	a_no_instant_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !$rose(rsp_valid))
		else $error("result appeared too early");

	// only crypt items carry data, and they always report ok
	a_flag_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status != rc4_pkg::ST_OK) |-> (rsp_out_byte == 8'd0))
		else $error("flagged result carries data");

endmodule

bind rc4_keystream_cipher rc4_checker u_rc4_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.req_valid    (req.valid),
	.req_ready    (req.ready),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.rsp_out_byte (rsp.out_byte),
	.rsp_status   (rsp.status)
);

`default_nettype wire

@@ bench/tb_rc4_keystream_cipher.sv @@
// Self-checking bench for rc4_keystream_cipher: queued stimulus, valid/ready driver,
// result checker and an in-bench RC4 predictor of the engine.
// Depends on rc4_pkg and the channel interfaces in rc4_if.sv.
`timescale 1ns / 1ps

module tb_rc4_keystream_cipher;

	// operation code 3 has no enum member; the engine must answer it with zeros
	localparam logic [1:0] OP_UNUSED = 2'd3;

	// covers a run where every item waits out the longest gaps on both sides
	// and a fair share of them are full key schedules, several times over
	localparam int unsigned CYCLE_LIMIT = 3_000_000;

	// longest single step is a schedule
	localparam int DRAIN_CYCLES = 1100;

	// long receiver hold-off that backs the engine up into its input
	localparam int HOLD_AT_RESULT = 150;
	localparam int HOLD_CYCLES    = 400;

	// least number of items queued, directed part included
	localparam int ITEM_TARGET = 600;

	typedef struct {
		logic [1:0] op;
		logic [7:0] data;
		logic       last_msg;
	} cipher_item_t;

	typedef struct {
		logic [7:0]       out_byte;
		rc4_pkg::status_t status;
	} cipher_result_t;

	logic clk;
	logic arst_n;

	rc4_req_if req_ch();
	rc4_rsp_if rsp_ch();

	rc4_keystream_cipher i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// item source and result store
	cipher_item_t   pending_q[$];
	cipher_result_t expected_q[$];

	// predictor state, mirrors the engine
	logic [7:0] perm_m[0:255];
	logic [7:0] key_m[0:rc4_pkg::KEY_DEPTH-1];
	logic [8:0] key_len_m;
	logic [7:0] i_m;
	logic [7:0] j_m;

	// generator bookkeeping: pending key length and whether key entry 0 holds a byte
	int unsigned gen_key_cnt;
	bit          key0_written;

	// driver and monitor state
	cipher_item_t   cur_item;
	cipher_result_t predicted;
	cipher_result_t want;
	bit             offering;
	int unsigned    send_wait;
	int unsigned    sent_cnt;
	int unsigned    recv_wait;
	int unsigned    recv_cnt;
	int unsigned    hold_left;
	bit             ready_next;
	int unsigned    err_count;
	int unsigned    cycle_cnt;
	int             k;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Per-item wait drawn at random; every fourth stretch of 40 items runs without gaps.
	function automatic int unsigned draw_wait(input int unsigned seq);
		if ((seq / 40) % 4 == 3)
			return 0;
		return $urandom_range(0, 19);
	endfunction

	// RC4 step on the predictor state: one result per item.
	task automatic cipher_predict(input cipher_item_t item, output cipher_result_t res);
		int         n;
		int         len;
		logic [7:0] held;
		logic [7:0] a;
		logic [7:0] b;
		logic [7:0] j;
		res.out_byte = 8'h00;
		res.status   = rc4_pkg::ST_OK;
		case (item.op)
			rc4_pkg::OP_LOAD: begin
				if (key_len_m < rc4_pkg::KEY_DEPTH) begin
					key_m[key_len_m] = item.data;
					key_len_m = key_len_m + 9'd1;
				end else begin
					res.status = rc4_pkg::ST_FULL;
				end
			end
			rc4_pkg::OP_SCHEDULE: begin
				len = key_len_m;
				// empty key: run as a one-byte key made of entry 0
				if (len == 0) begin
					len = 1;
					res.status = rc4_pkg::ST_EMPTY_KEY;
				end
				for (n = 0; n < 256; n++)
					perm_m[n] = 8'(n);
				j = 8'h00;
				for (n = 0; n < 256; n++) begin
					held = perm_m[n];
					j = j + held + key_m[n % len];
					perm_m[n] = perm_m[j];
					perm_m[j] = held;
				end
				key_len_m = 9'd0;
				i_m = 8'h00;
				j_m = 8'h00;
			end
			rc4_pkg::OP_CRYPT: begin
				i_m = i_m + 8'd1;
				a = perm_m[i_m];
				j_m = j_m + a;
				b = perm_m[j_m];
				perm_m[i_m] = b;
				perm_m[j_m] = a;
				res.out_byte = item.data ^ perm_m[8'(a + b)];
				if (item.last_msg) begin
					i_m = 8'h00;
					j_m = 8'h00;
				end
			end
			default: ;
		endcase
	endtask

	// Append one item, with a key load before it where needed; tracks the key length
	// so an empty-key schedule never reads a key entry that was never loaded.
	task automatic queue_item(input logic [1:0] op, input logic [7:0] data, input logic last_msg);
		cipher_item_t item;
		if (op == rc4_pkg::OP_SCHEDULE && gen_key_cnt == 0 && !key0_written) begin
			item.op = rc4_pkg::OP_LOAD;
			item.data = 8'($urandom);
			item.last_msg = 1'($urandom);
			pending_q.push_back(item);
			key0_written = 1'b1;
		end
		if (op == rc4_pkg::OP_LOAD) begin
			if (gen_key_cnt == 0)
				key0_written = 1'b1;
			if (gen_key_cnt < rc4_pkg::KEY_DEPTH)
				gen_key_cnt++;
		end else if (op == rc4_pkg::OP_SCHEDULE) begin
			gen_key_cnt = 0;
		end
		item.op = op;
		item.data = data;
		item.last_msg = last_msg;
		pending_q.push_back(item);
	endtask

	//--------------------------------------------------------------------
	// Driver: offers queued items, predicts each one as it is accepted.
	//--------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid           <= 1'b0;
			req_ch.operation       <= rc4_pkg::OP_LOAD;
			req_ch.data_byte       <= 8'h00;
			req_ch.last_of_message <= 1'b0;
			offering  = 1'b0;
			send_wait = 0;
			sent_cnt  = 0;
			for (k = 0; k < 256; k++)
				perm_m[k] = 8'(k);
			key_len_m = 9'd0;
			i_m = 8'h00;
			j_m = 8'h00;
		end else begin
			if (req_ch.valid && req_ch.ready) begin
				cipher_predict(cur_item, predicted);
				expected_q.push_back(predicted);
				offering = 1'b0;
				sent_cnt++;
				send_wait = draw_wait(sent_cnt);
			end
			if (!offering) begin
				if (send_wait > 0) begin
					send_wait--;
				end else if (pending_q.size() > 0) begin
					cur_item = pending_q.pop_front();
					offering = 1'b1;
				end
			end
			// one assignment per signal per edge; valid stays high across back-to-back items
			req_ch.valid           <= offering;
			req_ch.operation       <= cur_item.op;
			req_ch.data_byte       <= cur_item.data;
			req_ch.last_of_message <= cur_item.last_msg;
		end
	end

	//--------------------------------------------------------------------
	// Monitor: checks each result against the oldest prediction and paces
	// ready, with one long hold-off so the engine backs up.
	//--------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			recv_wait = 0;
			recv_cnt  = 0;
			hold_left = 0;
			err_count = 0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (expected_q.size() == 0) begin
					err_count++;
					if (err_count <= 50)
						$display("%0t: result with none pending: out_byte %02h status %0d",
							$time, rsp_ch.out_byte, rsp_ch.status);
				end else begin
					want = expected_q.pop_front();
					if (rsp_ch.out_byte !== want.out_byte) begin
						err_count++;
						if (err_count <= 50)
							$display("%0t: out_byte expected %02h actual %02h",
								$time, want.out_byte, rsp_ch.out_byte);
					end
					if (rsp_ch.status !== want.status) begin
						err_count++;
						if (err_count <= 50)
							$display("%0t: status expected %0d actual %0d",
								$time, want.status, rsp_ch.status);
					end
				end
				recv_cnt++;
				recv_wait = draw_wait(recv_cnt);
				if (recv_cnt == HOLD_AT_RESULT)
					hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				ready_next = 1'b0;
			end else if (recv_wait > 0) begin
				recv_wait--;
				ready_next = 1'b0;
			end else begin
				ready_next = 1'b1;
			end
			rsp_ch.ready <= ready_next;
		end
	end

	// timeout
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("rc4_keystream_cipher verification failed");
			$finish;
		end
	end

	//--------------------------------------------------------------------
	// Stimulus, reset and end of run.
	//--------------------------------------------------------------------
	initial begin
		int unsigned room;
		int unsigned pick;
		int unsigned len;
		int unsigned n;
		arst_n = 1'b0;
		cycle_cnt = 0;
		gen_key_cnt = 0;
		key0_written = 1'b0;

		// crypt on the reset (identity) permutation, both data extremes
		queue_item(rc4_pkg::OP_CRYPT, 8'h00, 1'b0);
		queue_item(rc4_pkg::OP_CRYPT, 8'hFF, 1'b1);
		// unused code answers zeros and leaves state alone
		queue_item(OP_UNUSED, 8'hFF, 1'b1);
		queue_item(OP_UNUSED, 8'h00, 1'b0);
		// two-byte key at the extremes; last bit on a load is ignored
		queue_item(rc4_pkg::OP_LOAD, 8'h00, 1'b0);
		queue_item(rc4_pkg::OP_LOAD, 8'hFF, 1'b1);
		queue_item(rc4_pkg::OP_SCHEDULE, 8'hFF, 1'b1);
		queue_item(rc4_pkg::OP_CRYPT, 8'h00, 1'b0);
		queue_item(rc4_pkg::OP_CRYPT, 8'hFF, 1'b0);
		queue_item(rc4_pkg::OP_CRYPT, 8'hA5, 1'b1);
		queue_item(rc4_pkg::OP_CRYPT, 8'h5A, 1'b0);
		// empty-key schedule reuses key entry 0, loaded above
		queue_item(rc4_pkg::OP_SCHEDULE, 8'h00, 1'b0);
		queue_item(rc4_pkg::OP_CRYPT, 8'hFF, 1'b1);
		queue_item(rc4_pkg::OP_LOAD, 8'h80, 1'b0);
		queue_item(rc4_pkg::OP_SCHEDULE, 8'h00, 1'b0);
		queue_item(rc4_pkg::OP_CRYPT, 8'h01, 1'b1);
		// full key store: 256 bytes, then two dropped bytes
		for (n = 0; n < rc4_pkg::KEY_DEPTH; n++)
			queue_item(rc4_pkg::OP_LOAD, 8'($urandom), 1'($urandom));
		queue_item(rc4_pkg::OP_LOAD, 8'hFF, 1'b1);
		queue_item(rc4_pkg::OP_LOAD, 8'h00, 1'b0);
		queue_item(rc4_pkg::OP_SCHEDULE, 8'h00, 1'b0);
		for (n = 0; n < 8; n++)
			queue_item(rc4_pkg::OP_CRYPT, 8'($urandom), 1'(n == 7));

		// random part: mostly keyed messages, some noise and broken sequences
		while (pending_q.size() < ITEM_TARGET) begin
			room = ITEM_TARGET - pending_q.size();
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16);
				for (n = 0; n < len; n++)
					queue_item(rc4_pkg::OP_LOAD, 8'($urandom), 1'($urandom));
				queue_item(rc4_pkg::OP_SCHEDULE, 8'($urandom), 1'($urandom));
				// occasionally run a long stream; message ends still fall at random within it
				len = ($urandom_range(0, 19) == 0) ? $urandom_range(200, 300) : $urandom_range(1, 24);
				if (len > room)
					len = room;
				for (n = 0; n < len; n++) begin
					if (n == len - 1)
						queue_item(rc4_pkg::OP_CRYPT, 8'($urandom), 1'($urandom_range(0, 3) != 0));
					else
						queue_item(rc4_pkg::OP_CRYPT, 8'($urandom), 1'($urandom_range(0, 31) == 0));
				end
			end else if (pick < 80) begin
				// keep streaming on the current permutation
				len = $urandom_range(1, 8);
				for (n = 0; n < len; n++)
					queue_item(rc4_pkg::OP_CRYPT, 8'($urandom), 1'($urandom));
			end else if (pick < 88) begin
				queue_item(rc4_pkg::OP_SCHEDULE, 8'($urandom), 1'($urandom));
			end else if (pick < 94) begin
				queue_item(OP_UNUSED, 8'($urandom), 1'($urandom));
			end else if (pick < 98 || room < rc4_pkg::KEY_DEPTH + 8) begin
				// stray key bytes that the next message key extends
				len = $urandom_range(1, 3);
				for (n = 0; n < len; n++)
					queue_item(rc4_pkg::OP_LOAD, 8'($urandom), 1'($urandom));
			end else begin
				// overfill the key store, then schedule
				len = rc4_pkg::KEY_DEPTH - gen_key_cnt + $urandom_range(1, 3);
				for (n = 0; n < len; n++)
					queue_item(rc4_pkg::OP_LOAD, 8'($urandom), 1'($urandom));
				queue_item(rc4_pkg::OP_SCHEDULE, 8'($urandom), 1'($urandom));
			end
		end

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_q.size() != 0 || req_ch.valid || expected_q.size() != 0)
			@(posedge clk);
		// catch any result beyond the last expected one
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (err_count == 0 && expected_q.size() == 0) begin
			$display("rc4_keystream_cipher verification clean");
		end else begin
			$display("rc4_keystream_cipher verification failed");
		end
		$finish;
	end

endmodule

@@ files.f @@
rtl/rc4_pkg.sv
rtl/rc4_if.sv
rtl/rc4_keystream_cipher.sv
rtl/rc4_checker.sv
bench/tb_rc4_keystream_cipher.sv
